/* rtl/saxpy_nonfinite_clear_defines.svh */
// Assertion macros shared by the SAXPY datapath modules.
// Needs nothing but a clock and an active-low reset in scope.
`ifndef SAXPY_NONFINITE_CLEAR_DEFINES_SVH
`define SAXPY_NONFINITE_CLEAR_DEFINES_SVH

// Implication checked at each rising clock edge, off during reset.
`define SNC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/snc_pkg.sv */
// Package for the SAXPY datapath: float field widths, constants, helpers.
// Needs nothing; used by every module of the block.
`default_nettype none
package snc_pkg;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned ManW  = 23;
  localparam int unsigned WordW = 32;
  localparam int unsigned SigW  = ManW + 1;
  localparam int unsigned ProdW = 2 * SigW;

  localparam logic [WordW-1:0] CanonNan = 32'h7FC0_0000;
  localparam logic [WordW-1:0] PosInf   = 32'h7F80_0000;

  // Multiplier-to-adder control bundle.
  typedef struct packed {
    logic                 pass;     // alpha is zero: result is y as given
    logic [WordW-1:0]     y;        // raw y (pass) or cleaned y
    logic                 nan;      // product is NaN
    logic                 inf;      // product is infinite
    logic                 zero;     // product is exactly zero
    logic                 sign;     // product sign
    logic signed [10:0]   exp;      // unbiased exponent of product bit 46
    logic [ProdW-1:0]     mant;     // raw 48-bit significand product
    logic                 last;
  } mul_to_add_t;

  // Unpacked operand: implicit bit restored, subnormal exponent fixed.
  function automatic logic [SigW-1:0] sig_of(input logic [WordW-1:0] b);
    sig_of = {(b[30:23] != '0), b[22:0]};
  endfunction

  function automatic logic [ExpW-1:0] exp_of(input logic [WordW-1:0] b);
    exp_of = (b[30:23] == '0) ? 8'd1 : b[30:23];
  endfunction

  function automatic logic is_nan(input logic [WordW-1:0] b);
    is_nan = (b[30:23] == '1) && (b[22:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [WordW-1:0] b);
    is_inf = (b[30:23] == '1) && (b[22:0] == '0);
  endfunction

  // Count of leading zeros over a 28-bit word.
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    lzc28 = n;
  endfunction
endpackage
`default_nettype wire

/* rtl/snc_stream_if.sv */
// Valid/ready stream interface for the SAXPY block channels.
// Needs nothing; the payload width is a parameter.
`default_nettype none
interface snc_stream_if #(
  parameter int unsigned DataW = 33
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/saxpy_nonfinite_clear.sv */
// Top level of the streaming SAXPY block with non-finite y clearing.
// Needs snc_pkg, snc_stream_if, snc_mul, snc_add and the macros header.
//
// Computes clean(y) + alpha*x in single precision, one item per cycle while
// the output is not stalled. Stages from input transfer to output register: a
// multiply register, product rounding, align/add, normalize/round, then the
// output register. A stalled output holds the whole pipeline, and the input
// is ready whenever the output register is empty or being drained. Alpha
// of +-0 returns y unchanged; other NaN results come out as 0x7FC00000.
`default_nettype none
module saxpy_nonfinite_clear (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  snc_stream_if.sink       in_if,
  snc_stream_if.source     out_if
);
  import snc_pkg::*;
  `include "saxpy_nonfinite_clear_defines.svh"

  logic [31:0] alpha_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  // Pipeline advances whenever the output register is free or drains.
  logic        en;
  logic        m_vld, p_vld, p_last;
  logic [31:0] p_res;
  mul_to_add_t m_bus;
  logic        o_vld_q, o_last_q;
  logic [31:0] o_res_q;

  assign en = !o_vld_q || out_if.ready;
  assign in_if.ready = en;

  snc_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid), .alpha_i(alpha_q),
    .x_i(in_if.data[64:33]), .y_i(in_if.data[32:1]), .last_i(in_if.data[0]),
    .vld_o(m_vld), .m_o(m_bus)
  );

  snc_add u_add (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m_vld), .m_i(m_bus),
    .vld_o(p_vld), .res_o(p_res), .last_o(p_last)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_res_q  <= p_res;
      o_last_q <= p_last;
    end
  end

  assign out_if.valid = o_vld_q;
  assign out_if.data  = {o_res_q, o_last_q};

  `SNC_ASSERT_NEXT(out_hold_chk, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.data), "output changed in stall")
  `SNC_ASSERT_IMPL(rdy_chk, clk_i, rst_ni, !out_if.valid, in_if.ready, "stalled while output empty")
  `SNC_ASSERT_NEXT(cfg_chk, clk_i, rst_ni, cfg_we_i, alpha_q == $past(cfg_wdata_i), "alpha write lost")
endmodule
`default_nettype wire

/* rtl/snc_mul.sv */
// Multiply stage: special-case decode and registered significand product.
// Needs snc_pkg.
`default_nettype none
module snc_mul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic [31:0]              alpha_i,
  input  wire logic [31:0]              x_i,
  input  wire logic [31:0]              y_i,
  input  wire logic                     last_i,
  output      logic                     vld_o,
  output      snc_pkg::mul_to_add_t     m_o
);
  import snc_pkg::*;

  logic        vld_q;
  mul_to_add_t m_q, m_d;
  logic        a_zero, x_zero;

  // Decode operands and form the exact product.
  always_comb begin
    a_zero = (alpha_i[30:0] == '0);
    x_zero = (x_i[30:0] == '0);
    m_d.pass = a_zero;
    m_d.y    = a_zero ? y_i : ((y_i[30:23] == '1) ? '0 : y_i);
    m_d.nan  = is_nan(alpha_i) || is_nan(x_i) ||
               (is_inf(alpha_i) && x_zero) || (is_inf(x_i) && a_zero);
    m_d.inf  = is_inf(alpha_i) || is_inf(x_i);
    m_d.zero = a_zero || x_zero;
    m_d.sign = alpha_i[31] ^ x_i[31];
    // exponent of bit 46 of the product, unbiased
    m_d.exp  = 11'(signed'({3'b0, exp_of(alpha_i)})) +
               11'(signed'({3'b0, exp_of(x_i)})) - 11'sd254;
    m_d.mant = sig_of(alpha_i) * sig_of(x_i);
    m_d.last = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  assign vld_o = vld_q;
  assign m_o   = m_q;
endmodule
`default_nettype wire

/* rtl/snc_add.sv */
// Add stages: product rounding, alignment, add, normalize, final rounding.
// Needs snc_pkg and the assertion macros header.
`default_nettype none
module snc_add (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire snc_pkg::mul_to_add_t m_i,
  output      logic                 vld_o,
  output      logic [31:0]          res_o,
  output      logic                 last_o
);
  import snc_pkg::*;
  `include "saxpy_nonfinite_clear_defines.svh"

  // ---------------- stage A: round the product to single ----------------
  logic        pr_spec;
  logic [31:0] pr_bits;
  logic        pr_nan;
  logic [47:0] nm;
  logic [5:0]  lz;
  logic signed [11:0] e1, eb;
  logic [49:0] shv;
  logic [23:0] kept;
  logic        gbit, sbit, rinc;
  logic [24:0] rnd;
  logic [7:0]  ef;
  logic [47:0] tmp;
  logic [7:0]  rsh;

  always_comb begin
    // highest set bit wins: scan upward, last hit is the msb
    lz = '0;
    for (int i = 0; i < 48; i++) begin
      if (m_i.mant[i]) begin
        lz = 6'(47 - i);
      end
    end
    nm  = m_i.mant << lz;
    e1  = 12'(m_i.exp) + 12'sd1 - 12'(signed'({6'b0, lz}));  // msb exponent
    eb  = e1 + 12'sd127;
    tmp = nm;
    if (eb < 12'sd1) begin
      rsh = (12'sd1 - eb > 12'sd49) ? 8'd49 : 8'(12'sd1 - eb);
      shv = {tmp, 2'b00} >> rsh;
      sbit = |({tmp, 2'b00} & ~({50{1'b1}} << rsh));
      ef = 8'd0;
    end else begin
      rsh = '0;
      shv = {tmp, 2'b00};
      sbit = 1'b0;
      ef = eb[7:0];
    end
    kept = shv[49:26];
    gbit = shv[25];
    sbit = sbit | (|shv[24:0]);
    rinc = gbit & (sbit | kept[0]);
    rnd  = {1'b0, kept} + 25'(rinc);
    pr_spec = 1'b0;
    pr_nan  = m_i.nan;
    pr_bits = '0;
    if (m_i.nan) begin
      pr_spec = 1'b1;
    end else if (m_i.inf || (eb > 12'sd254)) begin
      pr_bits = {m_i.sign, PosInf[30:0]};
    end else if (m_i.zero) begin
      pr_bits = {m_i.sign, 31'b0};
    end else if (rnd[24]) begin
      pr_bits = (ef == 8'd254) ? {m_i.sign, PosInf[30:0]}
                               : {m_i.sign, ef + 8'd1, 23'b0};
    end else if (ef == 8'd0) begin
      pr_bits = {m_i.sign, (rnd[23] ? 8'd1 : 8'd0), rnd[22:0]};
    end else begin
      pr_bits = {m_i.sign, ef, rnd[22:0]};
    end
  end

  logic        a_vld_q;
  logic        a_pass_q, a_nan_q, a_last_q;
  logic [31:0] a_y_q, a_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pass_q <= m_i.pass;
      a_nan_q  <= pr_nan | pr_spec;
      a_last_q <= m_i.last;
      a_y_q    <= m_i.y;
      a_p_q    <= pr_bits;
    end
  end

  // ---------------- stage B: align and add ----------------
  logic        big_y;
  logic [31:0] ob, os;
  logic [7:0]  eb_b, es_b, dexp;
  logic [26:0] mb, ms, msh;
  logic        stk;
  logic [27:0] sum;
  logic        sub;
  logic        b_inf, b_nan;
  logic [31:0] b_spec;

  always_comb begin
    big_y = (a_y_q[30:0] >= a_p_q[30:0]);
    ob = big_y ? a_y_q : a_p_q;
    os = big_y ? a_p_q : a_y_q;
    eb_b = exp_of(ob);
    es_b = exp_of(os);
    dexp = eb_b - es_b;
    mb = {sig_of(ob), 3'b000};
    ms = {sig_of(os), 3'b000};
    if (dexp > 8'd26) begin
      msh = '0;
      stk = |ms;
    end else begin
      msh = ms >> dexp;
      stk = |(ms & ~({27{1'b1}} << dexp));
    end
    sub = ob[31] ^ os[31];
    sum = sub ? ({1'b0, mb} - {1'b0, msh[26:1], msh[0] | stk})
              : ({1'b0, mb} + {1'b0, msh[26:1], msh[0] | stk});
    b_nan = a_nan_q;
    b_inf = (a_p_q[30:23] == '1);
    b_spec = CanonNan;
    if (b_inf) begin
      b_spec = a_p_q;
    end
  end

  logic        b_vld_q, b_last_q, b_pass_q, b_special_q, b_sign_q, b_zsign_q;
  logic [31:0] b_res_q;
  logic [7:0]  b_exp_q;
  logic [27:0] b_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_last_q    <= a_last_q;
      b_pass_q    <= a_pass_q;
      b_special_q <= b_nan | b_inf;
      b_res_q     <= a_pass_q ? a_y_q : (b_nan ? CanonNan : b_spec);
      b_sign_q    <= ob[31];
      b_zsign_q   <= a_y_q[31] & a_p_q[31];
      b_exp_q     <= eb_b;
      b_sum_q     <= sum;
    end
  end

  // ---------------- stage C: normalize and round ----------------
  logic [4:0]  nlz;
  logic [27:0] nsum;
  logic signed [9:0] ne;
  logic [4:0]  sh;
  logic [23:0] k2;
  logic        g2, s2, inc2;
  logic [24:0] r2;
  logic [7:0]  fe;
  logic [31:0] c_res;

  always_comb begin
    nlz = lzc28(b_sum_q);
    // bit 27 is carry; the msb is shifted up to bit 27
    ne = 10'(signed'({2'b0, b_exp_q})) + 10'sd1 - 10'(signed'({5'b0, nlz}));
    if (ne < 10'sd1) begin
      sh = 5'(10'(signed'({2'b0, b_exp_q})) - 10'sd0);  // shift to exponent 1
      fe = 8'd0;
    end else begin
      sh = nlz;
      fe = ne[7:0];
    end
    nsum = b_sum_q << sh;
    k2 = nsum[27:4];
    g2 = nsum[3];
    s2 = |nsum[2:0];
    inc2 = g2 & (s2 | k2[0]);
    r2 = {1'b0, k2} + 25'(inc2);
    if (b_pass_q || b_special_q) begin
      c_res = b_res_q;
    end else if (b_sum_q == '0) begin
      c_res = {b_zsign_q, 31'b0};
    end else if (r2[24]) begin
      c_res = (fe >= 8'd254) ? {b_sign_q, PosInf[30:0]}
                             : {b_sign_q, fe + 8'd1, 23'b0};
    end else if (fe == 8'd0 || !r2[23]) begin
      c_res = {b_sign_q, 7'b0, r2[23], r2[22:0]};
    end else if (fe == 8'd255) begin
      c_res = {b_sign_q, PosInf[30:0]};
    end else begin
      c_res = {b_sign_q, fe, r2[22:0]};
    end
  end

  logic        c_vld_q, c_last_q;
  logic [31:0] c_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_res_q  <= c_res;
      c_last_q <= b_last_q;
    end
  end

  assign vld_o  = c_vld_q;
  assign res_o  = c_res_q;
  assign last_o = c_last_q;

  `SNC_ASSERT_NEXT(a_adv_chk, clk_i, rst_ni, en_i && vld_i, a_vld_q, "stage A lost an item")
  `SNC_ASSERT_NEXT(b_hold_chk, clk_i, rst_ni, !en_i, $stable(b_vld_q), "stage B moved in stall")
  `SNC_ASSERT_IMPL(nan_chk, clk_i, rst_ni, c_vld_q && c_res_q[30:23] == 8'hFF && c_res_q[22:0] != '0 && !$past(b_pass_q), c_res_q == CanonNan, "non-canonical NaN")
endmodule
`default_nettype wire

/* dv/snc_scoreboard.sv */
// Scoreboard for the SAXPY block: bit-exact single-precision predictor and result queue.
// Needs nothing; the testbench top includes it by compile order.
class snc_scoreboard;
  typedef struct {
    logic [31:0] bits;
    logic        last;
  } saxpy_res_t;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  logic [31:0] alpha;
  saxpy_res_t  expected_q[$];
  int          errors;

  function new();
    alpha = '0;
    errors = 0;
  endfunction

  // Split a float into sign, integer significand and exponent of its lsb.
  function void unpack(input logic [31:0] b, output logic s, output logic [23:0] m,
                       output int e);
    s = b[31];
    if (b[30:23] == 8'd0) begin
      m = {1'b0, b[22:0]};
      e = -149;
    end else begin
      m = {1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  // Round sign * m * 2^e to single precision, nearest-even, with subnormals.
  function logic [31:0] round_pack(input logic s, input logic [127:0] m, input int e);
    int           p;
    int           elsb;
    int           sh;
    logic [127:0] q;
    logic [255:0] wide;
    logic         rb;
    logic         sb;
    p = -1;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    if (p < 0) return {s, 31'd0};
    elsb = p + e - 23;
    if (elsb < -149) elsb = -149;
    sh = elsb - e;
    rb = 1'b0;
    sb = 1'b0;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 128) begin
      q = '0;
      sb = 1'b1;
    end else begin
      wide = {m, 128'd0} >> sh;
      q = wide[255:128];
      rb = wide[127];
      sb = |wide[126:0];
    end
    if (rb && (sb || q[0])) q = q + 1;
    if (q[24]) begin
      q = q >> 1;
      elsb++;
    end
    if (elsb + 150 >= 255) return {s, 8'hFF, 23'd0};
    if (!q[23]) return {s, 8'd0, q[22:0]};
    return {s, 8'(elsb + 150), q[22:0]};
  endfunction

  function logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  function logic is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 0);
  endfunction

  function logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        sa;
    logic        sb;
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QNAN;
    if (is_inf(a) || is_inf(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
    unpack(a, sa, ma, ea);
    unpack(b, sb, mb, eb);
    return round_pack(sa ^ sb, 128'(ma) * 128'(mb), ea + eb);
  endfunction

  function logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic         sa;
    logic         sb;
    logic [23:0]  ma;
    logic [23:0]  mb;
    int           ea;
    int           eb;
    int           diff;
    int           e;
    logic [127:0] big;
    logic [127:0] lil;
    logic [31:0]  t;
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    // keep the larger exponent in a
    if (b[30:23] > a[30:23]) begin
      t = a;
      a = b;
      b = t;
    end
    unpack(a, sa, ma, ea);
    unpack(b, sb, mb, eb);
    diff = ea - eb;
    if (diff > 62) begin
      // small operand only matters as a sticky bit
      big = 128'(ma) << 39;
      lil = (mb != 0) ? 128'd1 : 128'd0;
      e = ea - 39;
    end else begin
      big = 128'(ma) << diff;
      lil = 128'(mb);
      e = eb;
    end
    if (sa == sb) return round_pack(sa, big + lil, e);
    if (big == lil) return 32'd0;
    if (big > lil) return round_pack(sa, big - lil, e);
    return round_pack(sb, lil - big, e);
  endfunction

  // Expected updated y for one element.
  function logic [31:0] saxpy_elem(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] yc;
    logic [31:0] r;
    if (alpha[30:0] == 0) return y;
    yc = (y[30:23] == 8'hFF) ? 32'd0 : y;
    r = fadd(yc, fmul(x, alpha));
    return is_nan(r) ? QNAN : r;
  endfunction

  function void note_input(input logic [31:0] x, input logic [31:0] y, input logic last);
    saxpy_res_t r;
    r.bits = saxpy_elem(x, y);
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function void check_result(input logic [31:0] bits, input logic last);
    saxpy_res_t r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result %h last %b", $time, bits, last);
      errors++;
      return;
    end
    r = expected_q.pop_front();
    if (r.bits !== bits) begin
      $display("%0t: result_bits expected %h actual %h", $time, r.bits, bits);
      errors++;
    end
    if (r.last !== last) begin
      $display("%0t: last_out expected %b actual %b", $time, r.last, last);
      errors++;
    end
  endfunction
endclass

/* dv/tb_saxpy_nonfinite_clear.sv */
// Testbench top for saxpy_nonfinite_clear: drives alpha settings and x/y streams.
// Needs snc_stream_if, the block RTL and snc_scoreboard.
module tb_saxpy_nonfinite_clear;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int CfgIdle = 12;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic no_idle;
  int   stall_left;
  int   quiet_cycles;

  snc_stream_if #(.DataW(65)) in_if ();
  snc_stream_if #(.DataW(33)) out_if ();

  snc_scoreboard sb;

  saxpy_nonfinite_clear dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: ready drops in random bursts unless no_idle is set.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (!no_idle && $urandom_range(7) == 0) begin
      out_if.ready = 1'b0;
      stall_left = $urandom_range(3);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Monitor both channels and count quiet cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.data[64:33], in_if.data[32:1], in_if.data[0]);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.data[32:1], out_if.data[0]);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_alpha(input logic [31:0] a);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = a;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.alpha = a;
  endtask

  // One transfer on the input channel, with an optional gap first.
  task automatic send_elem(input logic [31:0] x, input logic [31:0] y, input logic last);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(5) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data = {x, y, last};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (CfgIdle) @(negedge clk_i);
  endtask

  // Operand mix: specials, raw bits, tiny exponents, and values near 1.0 in magnitude.
  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[10];
    logic [31:0] v;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFF81_2345, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'h3F80_0000};
    case ($urandom_range(9))
      0: v = specials[$urandom_range(9)];
      1, 2, 3: v = $urandom;
      4, 5: begin
        v = $urandom;
        v[30:23] = 8'($urandom_range(0, 3));
      end
      default: begin
        v = $urandom;
        v[30:23] = 8'($urandom_range(110, 145));
      end
    endcase
    return v;
  endfunction

  task automatic random_items(input int n);
    for (int i = 0; i < n; i++)
      send_elem(pick_operand(), pick_operand(), ($urandom_range(15) == 0));
  endtask

  initial begin
    logic [31:0] alphas[12];
    sb = new();
    no_idle = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: specials under alpha = 1.0 and +inf, then alpha = +-0 passthrough
    write_alpha(32'h3F80_0000);
    send_elem(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_elem(32'h8000_0000, 32'h7FC0_0001, 1'b0);   // -0 product, NaN y -> +0
    send_elem(32'h8000_0000, 32'hFF80_0000, 1'b1);   // infinite y cleared
    send_elem(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);   // NaN x with payload
    send_elem(32'h7F80_0000, 32'h4000_0000, 1'b0);
    send_elem(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);   // overflow to inf
    send_elem(32'h0000_0001, 32'h8000_0001, 1'b0);   // subnormal cancellation
    send_elem(32'h3F80_0000, 32'hBF80_0000, 1'b1);
    send_elem(32'h3380_0000, 32'h3F80_0000, 1'b0);   // tie to even
    drain();
    write_alpha(32'h7F80_0000);
    send_elem(32'h0000_0000, 32'h3F80_0000, 1'b0);   // inf * 0
    send_elem(32'hFF80_0000, 32'h7F80_0000, 1'b1);   // -inf product, y cleared
    send_elem(32'h3F80_0000, 32'h4000_0000, 1'b0);
    drain();
    write_alpha(32'h8000_0000);
    send_elem(32'h3F80_0000, 32'h7F80_0001, 1'b1);   // alpha zero keeps NaN y
    send_elem(32'hFFFF_FFFF, 32'hFF80_0000, 1'b0);
    drain();
    write_alpha(32'h0000_0000);
    send_elem(32'h7F80_0000, 32'h7FFF_FFFF, 1'b1);
    send_elem(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Random phases over a range of alpha settings, extremes among them
    alphas = '{32'h3F80_0000, 32'hC020_0000, 32'h7F7F_FFFF, 32'h0000_0001,
               32'h8000_0000, 32'hFFC0_0000, 32'h0080_0000, 32'hFF7F_FFFF,
               32'h0000_0000, 32'h0, 32'h0, 32'h0};
    alphas[9] = $urandom;
    alphas[10] = $urandom;
    alphas[11] = {1'($urandom), 8'($urandom_range(120, 135)), 23'($urandom)};
    for (int k = 0; k < 12; k++) begin
      write_alpha(alphas[k]);
      if (k == 11) no_idle = 1'b1;
      random_items(70);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* saxpy_nonfinite_clear.f */
+incdir+rtl
rtl/snc_pkg.sv
rtl/snc_stream_if.sv
rtl/snc_mul.sv
rtl/snc_add.sv
rtl/saxpy_nonfinite_clear.sv
dv/snc_scoreboard.sv
dv/tb_saxpy_nonfinite_clear.sv
